/* rtl/stpg_pkg.sv */
// Shared types and constants of the speed/tach pulse gauge.
package stpg_pkg;

  localparam int THR_W     = 10;
  localparam int WIN_W     = 16;
  localparam int VAL_W     = 16;
  localparam int KIND_W    = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;

  // report kinds
  localparam logic [KIND_W-1:0] KIND_RPM   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SPEED = 2'd1;
  localparam logic [KIND_W-1:0] KIND_LAMP  = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPD_WIN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LIGHT_PER = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RPM_NUM   = 2'd3;

  // register reset values
  localparam logic [THR_W-1:0] THRESHOLD_RST = 10'd100;
  localparam logic [WIN_W-1:0] SPD_WIN_RST   = 16'd200;
  localparam logic [WIN_W-1:0] LIGHT_PER_RST = 16'd5000;
  localparam logic [VAL_W-1:0] RPM_NUM_RST   = 16'd60000;

  // pulse line phase: waiting for first high, high, low
  typedef enum logic [1:0] {
    PH_WAIT = 2'd0,
    PH_HIGH = 2'd1,
    PH_LOW  = 2'd2
  } phase_t;

endpackage

/* rtl/stpg_div.sv */
// Restoring divider, one quotient bit per cycle, for the rpm report.
module stpg_div import stpg_pkg::*; #(
  parameter int DIVISOR_W = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [VAL_W-1:0]     dividend,
  input  logic [DIVISOR_W-1:0] divisor,
  output logic                 done,
  output logic [VAL_W-1:0]     quotient
);

  localparam int CNT_W = $clog2(VAL_W + 1);

  logic                 busy;
  logic [CNT_W-1:0]     cnt;
  logic [DIVISOR_W-1:0] rem;
  logic [VAL_W-1:0]     quo;
  logic [DIVISOR_W-1:0] dsr;

  logic [DIVISOR_W:0]   trial;
  logic [DIVISOR_W:0]   diff;
  logic                 ge;

  assign trial = {rem, quo[VAL_W-1]};
  assign diff  = trial - {1'b0, dsr};
  assign ge    = trial >= {1'b0, dsr};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(VAL_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dsr <= divisor;
    end else if (busy) begin
      // remainder stays below the divisor, so it fits back in DIVISOR_W bits
      rem <= ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
      quo <= {quo[VAL_W-2:0], ge};
    end
  end

endmodule

/* rtl/speed_tach_pulse_gauge_core.sv */
// Top level of the speed/tach pulse gauge: level sensing, timers, reports.
//
//  channel  direction  handshake               payload
//  input    in         in_valid / in_stall     five samples, ms_tick
//  output   out        out_valid / out_stall   report_kind .. last
//  config   in         cfg_valid / cfg_ready   cfg_index, cfg_data
//
// An item passes through ST_EVAL, then ST_DIV for a tach report with a nonzero
// period, which waits on the bit-serial divider (16 quotient bits), then
// ST_SEND, which issues the item's reports one at a time.
// in_stall stays high from the accepting edge until the last report of the
// item sits in the output register; a stall on the output holds the sequencer.
// Synchronous reset restores the register defaults and clears all timers.
module speed_tach_pulse_gauge_core import stpg_pkg::*; #(
  parameter int SAMPLE_BITS = 10,
  parameter int TIME_BITS   = 32
) (
  input  logic                   clk,
  input  logic                   rst,

  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [SAMPLE_BITS-1:0] speed_sample,
  input  logic [SAMPLE_BITS-1:0] tach_sample,
  input  logic [SAMPLE_BITS-1:0] fuel_sample,
  input  logic [SAMPLE_BITS-1:0] water_sample,
  input  logic [SAMPLE_BITS-1:0] oil_sample,
  input  logic                   ms_tick,

  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [KIND_W-1:0]      report_kind,
  output logic [VAL_W-1:0]       report_value,
  output logic                   fuel_on,
  output logic                   water_temp_on,
  output logic                   oil_on,
  output logic                   last,

  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DAT_W-1:0]   cfg_data
);

  localparam int CMP_W = (SAMPLE_BITS > THR_W) ? SAMPLE_BITS : THR_W;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_EVAL = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_SEND = 4'b1000
  } state_t;

  state_t state;

  // configuration
  logic [THR_W-1:0] thr;
  logic [WIN_W-1:0] spd_win;
  logic [WIN_W-1:0] light_per;
  logic [VAL_W-1:0] rpm_num;

  // timing state
  logic [TIME_BITS-1:0] clock_ms;
  logic [TIME_BITS-1:0] spd_start;
  logic [TIME_BITS-1:0] tach_start;
  logic [TIME_BITS-1:0] light_start;
  phase_t               speed_phase;
  phase_t               tach_phase;
  logic [VAL_W-1:0]     speed_count;

  // captured samples
  logic [SAMPLE_BITS-1:0] s_spd, s_tach, s_fuel, s_water, s_oil;

  // pending reports and their values
  logic             pend_rpm, pend_spd, pend_lamp;
  logic [VAL_W-1:0] rpm_val;
  logic [VAL_W-1:0] spd_val;
  logic             lamp_fuel, lamp_water, lamp_oil;

  logic spd_hi, tach_hi, fuel_hi, water_hi, oil_hi;
  logic [TIME_BITS-1:0] period, spd_elapsed, light_elapsed;
  logic [VAL_W-1:0]     count_next;
  logic                 count_inc;
  phase_t               speed_phase_next;
  logic                 tach_fire;
  logic                 div_start, div_done;
  logic [VAL_W-1:0]     div_quo;
  logic                 slot_free;

  assign spd_hi   = CMP_W'(s_spd)   > CMP_W'(thr);
  assign tach_hi  = CMP_W'(s_tach)  > CMP_W'(thr);
  assign fuel_hi  = CMP_W'(s_fuel)  > CMP_W'(thr);
  assign water_hi = CMP_W'(s_water) > CMP_W'(thr);
  assign oil_hi   = CMP_W'(s_oil)   > CMP_W'(thr);

  assign period        = clock_ms - tach_start;
  assign spd_elapsed   = clock_ms - spd_start;
  assign light_elapsed = clock_ms - light_start;

  assign in_stall  = (state != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign slot_free = !out_valid || !out_stall;

  // speed edge counting
  always_comb begin
    speed_phase_next = speed_phase;
    count_inc        = 1'b0;
    case (speed_phase)
      PH_WAIT: if (spd_hi) speed_phase_next = PH_HIGH;
      PH_HIGH: if (!spd_hi) speed_phase_next = PH_LOW;
      PH_LOW: begin
        if (spd_hi) begin
          speed_phase_next = PH_HIGH;
          count_inc        = 1'b1;
        end
      end
      default: speed_phase_next = speed_phase;
    endcase
  end

  assign count_next = speed_count + VAL_W'(count_inc);
  assign tach_fire  = (tach_phase == PH_LOW) && tach_hi;
  assign div_start  = (state == ST_EVAL) && tach_fire && (period != '0);

  stpg_div #(.DIVISOR_W(TIME_BITS)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (rpm_num),
    .divisor  (period),
    .done     (div_done),
    .quotient (div_quo)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      thr       <= THRESHOLD_RST;
      spd_win   <= SPD_WIN_RST;
      light_per <= LIGHT_PER_RST;
      rpm_num   <= RPM_NUM_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_THRESHOLD: thr       <= cfg_data[THR_W-1:0];
        REG_SPD_WIN:   spd_win   <= cfg_data[WIN_W-1:0];
        REG_LIGHT_PER: light_per <= cfg_data[WIN_W-1:0];
        REG_RPM_NUM:   rpm_num   <= cfg_data[VAL_W-1:0];
        default: ;
      endcase
    end
  end

  // capture samples on accept
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s_spd   <= speed_sample;
      s_tach  <= tach_sample;
      s_fuel  <= fuel_sample;
      s_water <= water_sample;
      s_oil   <= oil_sample;
    end
  end

  // sequencer and timing state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      clock_ms    <= '0;
      spd_start   <= '0;
      tach_start  <= '0;
      light_start <= '0;
      speed_phase <= PH_WAIT;
      tach_phase  <= PH_WAIT;
      speed_count <= '0;
      pend_rpm    <= 1'b0;
      pend_spd    <= 1'b0;
      pend_lamp   <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;

      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            clock_ms <= clock_ms + TIME_BITS'(ms_tick);
            state    <= ST_EVAL;
          end
        end

        ST_EVAL: begin
          speed_phase <= speed_phase_next;

          case (tach_phase)
            PH_WAIT: if (tach_hi) tach_phase <= PH_HIGH;
            PH_HIGH: begin
              if (!tach_hi) begin
                tach_phase <= PH_LOW;
                tach_start <= clock_ms;
              end
            end
            PH_LOW: if (tach_hi) tach_phase <= PH_WAIT;
            default: tach_phase <= tach_phase;
          endcase
          pend_rpm <= tach_fire;
          rpm_val  <= rpm_num;

          if (spd_elapsed >= TIME_BITS'(spd_win)) begin
            pend_spd    <= 1'b1;
            spd_val     <= count_next;
            speed_count <= '0;
            spd_start   <= clock_ms;
          end else begin
            pend_spd    <= 1'b0;
            speed_count <= count_next;
          end

          pend_lamp  <= light_elapsed > TIME_BITS'(light_per);
          lamp_fuel  <= fuel_hi;
          lamp_water <= water_hi;
          lamp_oil   <= oil_hi;
          if (light_elapsed > TIME_BITS'(light_per)) light_start <= clock_ms;

          state <= div_start ? ST_DIV : ST_SEND;
        end

        ST_DIV: begin
          if (div_done) begin
            rpm_val <= div_quo;
            state   <= ST_SEND;
          end
        end

        ST_SEND: begin
          if (!pend_rpm && !pend_spd && !pend_lamp) begin
            state <= ST_IDLE;
          end else if (slot_free) begin
            out_valid <= 1'b1;
            if (pend_rpm) begin
              report_kind   <= KIND_RPM;
              report_value  <= rpm_val;
              fuel_on       <= 1'b0;
              water_temp_on <= 1'b0;
              oil_on        <= 1'b0;
              last          <= !(pend_spd || pend_lamp);
              pend_rpm      <= 1'b0;
              if (!(pend_spd || pend_lamp)) state <= ST_IDLE;
            end else if (pend_spd) begin
              report_kind   <= KIND_SPEED;
              report_value  <= spd_val;
              fuel_on       <= 1'b0;
              water_temp_on <= 1'b0;
              oil_on        <= 1'b0;
              last          <= !pend_lamp;
              pend_spd      <= 1'b0;
              if (!pend_lamp) state <= ST_IDLE;
            end else begin
              report_kind   <= KIND_LAMP;
              report_value  <= '0;
              fuel_on       <= lamp_fuel;
              water_temp_on <= lamp_water;
              oil_on        <= lamp_oil;
              last          <= 1'b1;
              pend_lamp     <= 1'b0;
              state         <= ST_IDLE;
            end
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

/* rtl/stpg_chk.sv */
// Port-level checker for the speed/tach pulse gauge, bound to the top level.
module stpg_chk import stpg_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic [KIND_W-1:0] report_kind,
  input logic              fuel_on,
  input logic              water_temp_on,
  input logic              oil_on,
  input logic              last
);

  // an accepted request leaves the block busy in the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken on two consecutive cycles");

  // while ready, only the final report of the previous request may wait
  a_idle_only_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !in_stall |-> last)
    else $error("ready while a non-final report is pending");

  // lamp flags appear only on lamp reports
  a_lamp_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid && report_kind != KIND_LAMP |-> !fuel_on && !water_temp_on && !oil_on)
    else $error("lamp flag set on a non-lamp report");

  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> report_kind == KIND_RPM || report_kind == KIND_SPEED ||
                  report_kind == KIND_LAMP)
    else $error("unknown report kind");

  // stalled report holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(report_kind) && $stable(last))
    else $error("stalled report changed");

endmodule

bind speed_tach_pulse_gauge_core stpg_chk u_stpg_chk (.*);
